[design/fla_pkg.sv]
// Shared constants and codes for the free-list heap allocator.
package fla_pkg;

    localparam int HEAP_BYTES_DEF  = 32768;
    localparam int ALIGN_BYTES_DEF = 8;

    localparam int WORD_W   = 16;
    localparam int CFG_W    = 16;
    localparam int TYPE_W   = 2;
    localparam int SIZE_W   = 16;
    localparam int ADDR_W   = 17;
    localparam int STAT_W   = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam int HDR_B    = 16;
    localparam int OVH_B    = 24;
    localparam int SPLIT_B  = 40;
    localparam int MIN_PAY  = 16;

    localparam logic [TYPE_W-1:0] RQ_ALLOC = 2'd0;
    localparam logic [TYPE_W-1:0] RQ_FREE  = 2'd1;
    localparam logic [TYPE_W-1:0] RQ_RESET = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    localparam logic REG_BASE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    localparam logic [CFG_W-1:0] LIMIT_RST = 16'h8000;

endpackage

[design/fla_if.sv]
// Request and response channel interfaces of the allocator.
interface fla_req_if;
    logic                      valid;
    logic                      ready;
    logic [fla_pkg::TYPE_W-1:0] req_type;
    logic [fla_pkg::SIZE_W-1:0] req_size;
    logic [fla_pkg::ADDR_W-1:0] req_addr;

    modport source (output valid, output req_type, output req_size, output req_addr,
                    input ready);
    modport sink (input valid, input req_type, input req_size, input req_addr,
                  output ready);
endinterface

interface fla_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [fla_pkg::STAT_W-1:0] status;
    logic [fla_pkg::ADDR_W-1:0] block_addr;

    modport source (output valid, output status, output block_addr, input ready);
    modport sink (input valid, input status, input block_addr, output ready);
endinterface

[design/fla_mem.sv]
// Heap word memory, one write port and one registered read port.
module fla_mem #(
    parameter int AW = 12,
    parameter int DW = 16
) (
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/fla_ctrl.sv]
// Allocator sequencer: list walk, bump, split, unlink, coalesce and push over the heap memory.
module fla_ctrl #(
    parameter int HEAP_BYTES  = fla_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES = fla_pkg::ALIGN_BYTES_DEF,
    localparam int AW = $clog2(HEAP_BYTES / 8)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    fla_req_if.sink                     req,
    fla_rsp_if.source                   rsp,
    input  logic [fla_pkg::CFG_W-1:0]   heap_base,
    input  logic [fla_pkg::CFG_W-1:0]   heap_limit,
    output logic                        mrd_en,
    output logic [AW-1:0]               mrd_addr,
    input  logic [fla_pkg::WORD_W-1:0]  mrd_data,
    output logic                        mwr_en,
    output logic [AW-1:0]               mwr_addr,
    output logic [fla_pkg::WORD_W-1:0]  mwr_data
);
    import fla_pkg::*;

    localparam int PW = $clog2(HEAP_BYTES) + 1;
    localparam int XW = ((PW > ADDR_W) ? PW : ADDR_W) + 2;
    localparam logic [AW-1:0] CNT_MAX = {AW{1'b1}};
    localparam logic [XW-1:0] ALIGN_M = XW'(ALIGN_BYTES - 1);
    localparam logic [XW-1:0] HEAP_X  = XW'(HEAP_BYTES);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_WALK_SZ = 5'd1;
    localparam logic [4:0] S_WALK_NX = 5'd2;
    localparam logic [4:0] S_HIT_LP  = 5'd3;
    localparam logic [4:0] S_HIT_LN  = 5'd4;
    localparam logic [4:0] S_SPLIT   = 5'd5;
    localparam logic [4:0] S_BUMP    = 5'd6;
    localparam logic [4:0] S_BUMP_WR = 5'd7;
    localparam logic [4:0] S_GRANT   = 5'd8;
    localparam logic [4:0] S_F_HD    = 5'd9;
    localparam logic [4:0] S_F_SZ    = 5'd10;
    localparam logic [4:0] S_F_NH    = 5'd11;
    localparam logic [4:0] S_F_NRD   = 5'd12;
    localparam logic [4:0] S_F_NSZ   = 5'd13;
    localparam logic [4:0] S_F_PRV   = 5'd14;
    localparam logic [4:0] S_F_PSZ   = 5'd15;
    localparam logic [4:0] S_F_PH    = 5'd16;
    localparam logic [4:0] S_F_PM    = 5'd17;
    localparam logic [4:0] S_F_WR    = 5'd18;
    localparam logic [4:0] S_F_TLA   = 5'd19;
    localparam logic [4:0] S_F_TL    = 5'd20;
    localparam logic [4:0] S_F_PUSH  = 5'd21;
    localparam logic [4:0] S_RM_A    = 5'd22;
    localparam logic [4:0] S_RM_LP   = 5'd23;
    localparam logic [4:0] S_RM_LN   = 5'd24;
    localparam logic [4:0] S_RM_W2   = 5'd25;
    localparam logic [4:0] S_DONE    = 5'd26;

    function automatic logic [XW-1:0] ext(input logic [WORD_W-1:0] v);
        ext = {{(XW-WORD_W){1'b0}}, v};
    endfunction

    logic [4:0]        state_reg, state_next;
    logic [4:0]        ret_reg, ret_next;
    logic [3:0]        step_reg, step_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [XW-1:0]     sz_reg, sz_next;
    logic [XW-1:0]     off_reg, off_next;
    logic [XW-1:0]     hd_reg, hd_next;
    logic [XW-1:0]     nh_reg, nh_next;
    logic [XW-1:0]     ph_reg, ph_next;
    logic [WORD_W-1:0] whole_reg, whole_next;
    logic [WORD_W-1:0] nd_reg, nd_next;
    logic [WORD_W-1:0] lp_reg, lp_next;
    logic [WORD_W-1:0] ln_reg, ln_next;
    logic [WORD_W-1:0] tl_reg, tl_next;
    logic [WORD_W-1:0] psz_reg, psz_next;
    logic [WORD_W-1:0] rnode_reg, rnode_next;
    logic [PW-1:0]     bump_reg, bump_next;
    logic [WORD_W-1:0] head_reg, head_next;
    logic              ne_reg, ne_next;
    logic [STAT_W-1:0] res_st_reg, res_st_next;
    logic [ADDR_W-1:0] res_ga_reg, res_ga_next;
    logic              ov_reg, ov_next;
    logic [STAT_W-1:0] ost_reg, ost_next;
    logic [ADDR_W-1:0] oga_reg, oga_next;

    logic [XW-1:0] rd_off, wr_off;
    logic [XW-1:0] rnd_a, rnd_b, rnd_sz;
    logic [XW-1:0] f_off, rem, rsz, lim, nd_x, hd_x, bump_x;
    logic          single;

    assign nd_x   = ext(nd_reg);
    assign hd_x   = hd_reg;
    assign bump_x = XW'(bump_reg);
    assign rem    = nd_x + sz_reg + XW'(OVH_B);
    assign rsz    = ext(whole_reg) - sz_reg - XW'(OVH_B);
    assign single = (ln_reg == nd_reg);
    assign lim    = (ext(heap_limit) > HEAP_X) ? HEAP_X : ext(heap_limit);
    assign f_off  = XW'(req.req_addr) - ext(heap_base);

    assign rnd_a  = (XW'(req.req_size) + ALIGN_M) & ~ALIGN_M;
    assign rnd_b  = (rnd_a + XW'(7)) & ~XW'(7);
    assign rnd_sz = (rnd_b < XW'(MIN_PAY)) ? XW'(MIN_PAY) : rnd_b;

    assign mrd_addr = rd_off[3 +: AW];
    assign mwr_addr = wr_off[3 +: AW];

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = ov_reg;
    assign rsp.status     = ost_reg;
    assign rsp.block_addr = oga_reg;

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        step_next   = step_reg;
        cnt_next    = cnt_reg;
        sz_next     = sz_reg;
        off_next    = off_reg;
        hd_next     = hd_reg;
        nh_next     = nh_reg;
        ph_next     = ph_reg;
        whole_next  = whole_reg;
        nd_next     = nd_reg;
        lp_next     = lp_reg;
        ln_next     = ln_reg;
        tl_next     = tl_reg;
        psz_next    = psz_reg;
        rnode_next  = rnode_reg;
        bump_next   = bump_reg;
        head_next   = head_reg;
        ne_next     = ne_reg;
        res_st_next = res_st_reg;
        res_ga_next = res_ga_reg;
        ov_next     = ov_reg && !rsp.ready;
        ost_next    = ost_reg;
        oga_next    = oga_reg;
        mrd_en      = 1'b0;
        rd_off      = '0;
        mwr_en      = 1'b0;
        wr_off      = '0;
        mwr_data    = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    res_ga_next = '0;
                    case (req.req_type)
                        RQ_ALLOC:
                        begin
                            sz_next = rnd_sz;
                            if (ne_reg)
                            begin
                                nd_next    = head_reg;
                                cnt_next   = '0;
                                mrd_en     = 1'b1;
                                rd_off     = ext(head_reg) + XW'(8);
                                state_next = S_WALK_SZ;
                            end
                            else
                            begin
                                state_next = S_BUMP;
                            end
                        end
                        RQ_FREE:
                        begin
                            if ((XW'(req.req_addr) < ext(heap_base) + XW'(HDR_B)) ||
                                (XW'(req.req_addr) >= ext(heap_base) + bump_x) ||
                                (f_off[2:0] != 3'd0))
                            begin
                                res_st_next = ST_INVALID;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                off_next   = f_off;
                                hd_next    = f_off - XW'(HDR_B);
                                mrd_en     = 1'b1;
                                rd_off     = f_off - XW'(HDR_B);
                                state_next = S_F_HD;
                            end
                        end
                        RQ_RESET:
                        begin
                            bump_next   = '0;
                            head_next   = '0;
                            ne_next     = 1'b0;
                            res_st_next = ST_OK;
                            state_next  = S_DONE;
                        end
                        default:
                        begin
                            res_st_next = ST_INVALID;
                            state_next  = S_DONE;
                        end
                    endcase
                end
            end
            S_WALK_SZ:
            begin
                mrd_en = 1'b1;
                if (ext(mrd_data) >= sz_reg)
                begin
                    whole_next = mrd_data;
                    rd_off     = nd_x + XW'(16);
                    state_next = S_HIT_LP;
                end
                else
                begin
                    rd_off     = nd_x + XW'(24);
                    state_next = S_WALK_NX;
                end
            end
            S_WALK_NX:
            begin
                if ((mrd_data == head_reg) || (cnt_reg == CNT_MAX))
                begin
                    state_next = S_BUMP;
                end
                else
                begin
                    nd_next    = mrd_data;
                    cnt_next   = cnt_reg + 1'b1;
                    mrd_en     = 1'b1;
                    rd_off     = ext(mrd_data) + XW'(8);
                    state_next = S_WALK_SZ;
                end
            end
            S_HIT_LP:
            begin
                lp_next    = mrd_data;
                mrd_en     = 1'b1;
                rd_off     = nd_x + XW'(24);
                state_next = S_HIT_LN;
            end
            S_HIT_LN:
            begin
                ln_next  = mrd_data;
                mwr_en   = 1'b1;
                wr_off   = nd_x;
                mwr_data = WORD_W'(1);
                if (ext(whole_reg) >= sz_reg + XW'(SPLIT_B))
                begin
                    step_next  = '0;
                    state_next = S_SPLIT;
                end
                else
                begin
                    rnode_next = nd_reg;
                    ret_next   = S_GRANT;
                    state_next = S_RM_A;
                end
            end
            S_SPLIT:
            begin
                mwr_en    = 1'b1;
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        wr_off   = nd_x + XW'(8);
                        mwr_data = sz_reg[WORD_W-1:0];
                    end
                    4'd1:
                    begin
                        wr_off   = nd_x + XW'(HDR_B) + sz_reg;
                        mwr_data = sz_reg[WORD_W-1:0];
                    end
                    4'd2:
                    begin
                        wr_off   = rem;
                        mwr_data = '0;
                    end
                    4'd3:
                    begin
                        wr_off   = rem + XW'(8);
                        mwr_data = rsz[WORD_W-1:0];
                    end
                    4'd4:
                    begin
                        wr_off   = rem + XW'(HDR_B) + rsz;
                        mwr_data = rsz[WORD_W-1:0];
                    end
                    4'd5:
                    begin
                        wr_off   = rem + XW'(16);
                        mwr_data = single ? rem[WORD_W-1:0] : lp_reg;
                    end
                    4'd6:
                    begin
                        wr_off   = rem + XW'(24);
                        mwr_data = single ? rem[WORD_W-1:0] : ln_reg;
                    end
                    4'd7:
                    begin
                        wr_off   = ext(lp_reg) + XW'(24);
                        mwr_data = rem[WORD_W-1:0];
                    end
                    default:
                    begin
                        wr_off   = ext(ln_reg) + XW'(16);
                        mwr_data = rem[WORD_W-1:0];
                    end
                endcase
                if ((single && step_reg == 4'd6) || step_reg == 4'd8)
                begin
                    if (head_reg == nd_reg)
                    begin
                        head_next = rem[WORD_W-1:0];
                    end
                    state_next = S_GRANT;
                end
            end
            S_BUMP:
            begin
                if (bump_x + XW'(OVH_B) + sz_reg > lim)
                begin
                    res_st_next = ST_NOSPACE;
                    state_next  = S_DONE;
                end
                else
                begin
                    nd_next    = bump_reg[WORD_W-1:0];
                    step_next  = '0;
                    state_next = S_BUMP_WR;
                end
            end
            S_BUMP_WR:
            begin
                mwr_en    = 1'b1;
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        wr_off   = bump_x;
                        mwr_data = WORD_W'(1);
                    end
                    4'd1:
                    begin
                        wr_off   = bump_x + XW'(8);
                        mwr_data = sz_reg[WORD_W-1:0];
                    end
                    default:
                    begin
                        wr_off    = bump_x + XW'(HDR_B) + sz_reg;
                        mwr_data  = sz_reg[WORD_W-1:0];
                        bump_next = PW'(bump_x + sz_reg + XW'(OVH_B));
                        state_next = S_GRANT;
                    end
                endcase
            end
            S_GRANT:
            begin
                res_st_next = ST_OK;
                res_ga_next = ADDR_W'(ext(heap_base) + nd_x + XW'(HDR_B));
                state_next  = S_DONE;
            end
            S_F_HD:
            begin
                if (mrd_data == '0)
                begin
                    res_st_next = ST_INVALID;
                    state_next  = S_DONE;
                end
                else
                begin
                    mrd_en     = 1'b1;
                    rd_off     = hd_x + XW'(8);
                    state_next = S_F_SZ;
                end
            end
            S_F_SZ:
            begin
                sz_next = ext(mrd_data);
                nh_next = off_reg + ext(mrd_data) + XW'(8);
                if (off_reg + ext(mrd_data) + XW'(8) < bump_x)
                begin
                    mrd_en     = 1'b1;
                    rd_off     = off_reg + ext(mrd_data) + XW'(8);
                    state_next = S_F_NH;
                end
                else
                begin
                    state_next = S_F_PRV;
                end
            end
            S_F_NH:
            begin
                if (mrd_data == '0)
                begin
                    rnode_next = nh_reg[WORD_W-1:0];
                    ret_next   = S_F_NRD;
                    state_next = S_RM_A;
                end
                else
                begin
                    state_next = S_F_PRV;
                end
            end
            S_F_NRD:
            begin
                mrd_en     = 1'b1;
                rd_off     = nh_reg + XW'(8);
                state_next = S_F_NSZ;
            end
            S_F_NSZ:
            begin
                sz_next    = sz_reg + ext(mrd_data) + XW'(OVH_B);
                state_next = S_F_PRV;
            end
            S_F_PRV:
            begin
                step_next = '0;
                if (hd_reg != '0)
                begin
                    mrd_en     = 1'b1;
                    rd_off     = off_reg - XW'(24);
                    state_next = S_F_PSZ;
                end
                else
                begin
                    state_next = S_F_WR;
                end
            end
            S_F_PSZ:
            begin
                psz_next   = mrd_data;
                ph_next    = off_reg - XW'(SPLIT_B) - ext(mrd_data);
                mrd_en     = 1'b1;
                rd_off     = off_reg - XW'(SPLIT_B) - ext(mrd_data);
                state_next = S_F_PH;
            end
            S_F_PH:
            begin
                step_next = '0;
                if (mrd_data == '0)
                begin
                    rnode_next = ph_reg[WORD_W-1:0];
                    ret_next   = S_F_PM;
                    state_next = S_RM_A;
                end
                else
                begin
                    state_next = S_F_WR;
                end
            end
            S_F_PM:
            begin
                sz_next    = sz_reg + ext(psz_reg) + XW'(OVH_B);
                hd_next    = ph_reg;
                step_next  = '0;
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                mwr_en    = 1'b1;
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        wr_off   = hd_x;
                        mwr_data = '0;
                    end
                    4'd1:
                    begin
                        wr_off   = hd_x + XW'(8);
                        mwr_data = sz_reg[WORD_W-1:0];
                    end
                    default:
                    begin
                        wr_off     = hd_x + XW'(HDR_B) + sz_reg;
                        mwr_data   = sz_reg[WORD_W-1:0];
                        step_next  = '0;
                        state_next = ne_reg ? S_F_TLA : S_F_PUSH;
                    end
                endcase
            end
            S_F_TLA:
            begin
                mrd_en     = 1'b1;
                rd_off     = ext(head_reg) + XW'(16);
                state_next = S_F_TL;
            end
            S_F_TL:
            begin
                tl_next    = mrd_data;
                step_next  = '0;
                state_next = S_F_PUSH;
            end
            S_F_PUSH:
            begin
                mwr_en    = 1'b1;
                step_next = step_reg + 1'b1;
                case (step_reg)
                    4'd0:
                    begin
                        wr_off   = hd_x + XW'(16);
                        mwr_data = ne_reg ? tl_reg : hd_reg[WORD_W-1:0];
                    end
                    4'd1:
                    begin
                        wr_off   = hd_x + XW'(24);
                        mwr_data = ne_reg ? head_reg : hd_reg[WORD_W-1:0];
                    end
                    4'd2:
                    begin
                        wr_off   = ext(tl_reg) + XW'(24);
                        mwr_data = hd_reg[WORD_W-1:0];
                    end
                    default:
                    begin
                        wr_off   = ext(head_reg) + XW'(16);
                        mwr_data = hd_reg[WORD_W-1:0];
                    end
                endcase
                if ((!ne_reg && step_reg == 4'd1) || step_reg == 4'd3)
                begin
                    head_next   = hd_reg[WORD_W-1:0];
                    ne_next     = 1'b1;
                    res_st_next = ST_OK;
                    state_next  = S_DONE;
                end
            end
            S_RM_A:
            begin
                mrd_en     = 1'b1;
                rd_off     = ext(rnode_reg) + XW'(16);
                state_next = S_RM_LP;
            end
            S_RM_LP:
            begin
                lp_next    = mrd_data;
                mrd_en     = 1'b1;
                rd_off     = ext(rnode_reg) + XW'(24);
                state_next = S_RM_LN;
            end
            S_RM_LN:
            begin
                ln_next = mrd_data;
                if (mrd_data == rnode_reg)
                begin
                    ne_next    = 1'b0;
                    state_next = ret_reg;
                end
                else
                begin
                    mwr_en     = 1'b1;
                    wr_off     = ext(lp_reg) + XW'(24);
                    mwr_data   = mrd_data;
                    state_next = S_RM_W2;
                end
            end
            S_RM_W2:
            begin
                mwr_en   = 1'b1;
                wr_off   = ext(ln_reg) + XW'(16);
                mwr_data = lp_reg;
                if (head_reg == rnode_reg)
                begin
                    head_next = ln_reg;
                end
                state_next = ret_reg;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next    = 1'b1;
                    ost_next   = res_st_reg;
                    oga_next   = res_ga_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            step_reg  <= '0;
            cnt_reg   <= '0;
            bump_reg  <= '0;
            head_reg  <= '0;
            ne_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            step_reg  <= step_next;
            cnt_reg   <= cnt_next;
            bump_reg  <= bump_next;
            head_reg  <= head_next;
            ne_reg    <= ne_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sz_reg     <= sz_next;
        off_reg    <= off_next;
        hd_reg     <= hd_next;
        nh_reg     <= nh_next;
        ph_reg     <= ph_next;
        whole_reg  <= whole_next;
        nd_reg     <= nd_next;
        lp_reg     <= lp_next;
        ln_reg     <= ln_next;
        tl_reg     <= tl_next;
        psz_reg    <= psz_next;
        rnode_reg  <= rnode_next;
        res_st_reg <= res_st_next;
        res_ga_reg <= res_ga_next;
        ost_reg    <= ost_next;
        oga_reg    <= oga_next;
    end

endmodule

[design/free_list_heap_allocator.sv]
// Reset, an unknown type and an out-of-range free go straight to the response; a valid free
// coalesces with free neighbours and pushes. Allocate walks the free list node by node, then
// bumps (or answers out of space) or, on a hit, splits the node or unlinks it.
// Requests are served one at a time over the one-read, one-write heap memory; a response
// register lets the next request enter while the last response waits.
// Reset clears control state, the free list and the bump pointer; heap words get no clearing.
module free_list_heap_allocator #(
    parameter int HEAP_BYTES  = fla_pkg::HEAP_BYTES_DEF,
    parameter int ALIGN_BYTES = fla_pkg::ALIGN_BYTES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    fla_req_if.sink                      req,
    fla_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fla_pkg::PADDR_W-1:0]  paddr,
    input  logic [fla_pkg::PDATA_W-1:0]  pwdata,
    output logic [fla_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import fla_pkg::*;

    localparam int AW = $clog2(HEAP_BYTES / 8);

    logic [CFG_W-1:0]  base_reg, base_next;
    logic [CFG_W-1:0]  limit_reg, limit_next;
    logic              mrd_en, mwr_en;
    logic [AW-1:0]     mrd_addr, mwr_addr;
    logic [WORD_W-1:0] mrd_data, mwr_data;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LIMIT) ? PDATA_W'(limit_reg) : PDATA_W'(base_reg);

    always_comb
    begin
        base_next  = base_reg;
        limit_next = limit_reg;
        if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_BASE)
            begin
                base_next = pwdata[CFG_W-1:0];
            end
            else
            begin
                limit_next = pwdata[CFG_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            limit_reg <= LIMIT_RST;
        end
        else
        begin
            base_reg  <= base_next;
            limit_reg <= limit_next;
        end
    end

    fla_ctrl #(
        .HEAP_BYTES  (HEAP_BYTES),
        .ALIGN_BYTES (ALIGN_BYTES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .rsp        (rsp),
        .heap_base  (base_reg),
        .heap_limit (limit_reg),
        .mrd_en     (mrd_en),
        .mrd_addr   (mrd_addr),
        .mrd_data   (mrd_data),
        .mwr_en     (mwr_en),
        .mwr_addr   (mwr_addr),
        .mwr_data   (mwr_data)
    );

    fla_mem #(
        .AW (AW),
        .DW (WORD_W)
    ) u_mem (
        .clk     (clk),
        .rd_en   (mrd_en),
        .rd_addr (mrd_addr),
        .rd_data (mrd_data),
        .wr_en   (mwr_en),
        .wr_addr (mwr_addr),
        .wr_data (mwr_data)
    );

`ifndef SYNTHESIS
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("request accepted while busy");

    a_zero_addr_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.block_addr == '0)
        else $error("failed response carries an address");

    a_rsp_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(!req.ready))
        else $error("response raised without a request in flight");
`endif

endmodule

[sim/tb.sv]
// Self-checking testbench for the free-list heap allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module tb;
    import fla_pkg::*;

    localparam int MEM_WORDS  = HEAP_BYTES_DEF / 8;
    localparam int CYCLE_CAP  = 20000000;
    localparam logic [TYPE_W-1:0] RQ_BAD = 2'd3;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] block_addr;
    } grant_t;

    typedef struct {
        logic [TYPE_W-1:0] kind;
        int unsigned       size;
        int unsigned       addr;
        bit                typed;
        logic [STAT_W-1:0] status;
        logic [ADDR_W-1:0] block_addr;
    } row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    fla_req_if req_ch();
    fla_rsp_if rsp_ch();

    free_list_heap_allocator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    int unsigned heap_mem [MEM_WORDS];
    bit          heap_set [MEM_WORDS];
    int unsigned mem_keep [MEM_WORDS];
    bit          set_keep [MEM_WORDS];
    int unsigned bump_end;
    int unsigned list_head;
    bit          list_busy;
    bit          read_unset;
    int unsigned cfg_base;
    int unsigned cfg_limit;

    grant_t      pending_grants[$];
    int unsigned live_blocks[$];
    int unsigned freed_blocks[$];
    int          fails;
    int          checked;
    int          cycles;
    bit          calm;
    int          n_grant;
    int          n_nospace;
    int          n_release;
    int          n_invalid;
    row_t        rows[21];

    function automatic int unsigned mem_rd(int unsigned off);
        int unsigned idx;
        idx = (off >> 3) % MEM_WORDS;
        if (!heap_set[idx])
            read_unset = 1'b1;
        return heap_mem[idx];
    endfunction

    function automatic void mem_wr(int unsigned off, int unsigned v);
        int unsigned idx;
        idx = (off >> 3) % MEM_WORDS;
        heap_mem[idx] = v;
        heap_set[idx] = 1'b1;
    endfunction

    function automatic void unlink_node(int unsigned nd);
        int unsigned lp;
        int unsigned ln;
        lp = mem_rd(nd + 16);
        ln = mem_rd(nd + 24);
        if (ln == nd)
        begin
            list_busy = 1'b0;
            return;
        end
        mem_wr(lp + 24, ln);
        mem_wr(ln + 16, lp);
        if (list_head == nd)
            list_head = ln;
    endfunction

    function automatic void push_node(int unsigned nd);
        int unsigned tl;
        if (!list_busy)
        begin
            mem_wr(nd + 16, nd);
            mem_wr(nd + 24, nd);
        end
        else
        begin
            tl = mem_rd(list_head + 16);
            mem_wr(nd + 16, tl);
            mem_wr(nd + 24, list_head);
            mem_wr(tl + 24, nd);
            mem_wr(list_head + 16, nd);
        end
        list_head = nd;
        list_busy = 1'b1;
    endfunction

    function automatic logic [STAT_W-1:0] carve_block(int unsigned want,
                                                      output int unsigned grant);
        int unsigned sz;
        int unsigned lim;
        int unsigned nd;
        int unsigned nx;
        int unsigned whole;
        int unsigned lp;
        int unsigned ln;
        int unsigned rem;
        int unsigned rsz;
        bit          hit;
        grant = 0;
        sz = want;
        if (sz % ALIGN_BYTES_DEF != 0)
            sz += ALIGN_BYTES_DEF - sz % ALIGN_BYTES_DEF;
        sz = (sz + 7) & ~32'd7;
        if (sz < MIN_PAY)
            sz = MIN_PAY;
        if (list_busy)
        begin
            nd = list_head;
            hit = 1'b0;
            for (int i = 0; i < MEM_WORDS; i++)
            begin
                if (mem_rd(nd + 8) >= sz)
                begin
                    hit = 1'b1;
                    break;
                end
                nx = mem_rd(nd + 24);
                if (nx == list_head)
                    break;
                nd = nx;
            end
            if (hit)
            begin
                whole = mem_rd(nd + 8);
                lp = mem_rd(nd + 16);
                ln = mem_rd(nd + 24);
                mem_wr(nd, 1);
                if (whole >= sz + SPLIT_B)
                begin
                    rem = nd + sz + OVH_B;
                    rsz = whole - sz - OVH_B;
                    mem_wr(nd + 8, sz);
                    mem_wr(nd + HDR_B + sz, sz);
                    mem_wr(rem, 0);
                    mem_wr(rem + 8, rsz);
                    mem_wr(rem + HDR_B + rsz, rsz);
                    if (ln == nd)
                    begin
                        mem_wr(rem + 16, rem);
                        mem_wr(rem + 24, rem);
                    end
                    else
                    begin
                        mem_wr(rem + 16, lp);
                        mem_wr(rem + 24, ln);
                        mem_wr(lp + 24, rem);
                        mem_wr(ln + 16, rem);
                    end
                    if (list_head == nd)
                        list_head = rem;
                end
                else
                    unlink_node(nd);
                grant = nd + HDR_B;
                return ST_OK;
            end
        end
        lim = (cfg_limit > HEAP_BYTES_DEF) ? HEAP_BYTES_DEF : cfg_limit;
        if (bump_end + OVH_B + sz > lim)
            return ST_NOSPACE;
        mem_wr(bump_end, 1);
        mem_wr(bump_end + 8, sz);
        mem_wr(bump_end + HDR_B + sz, sz);
        grant = bump_end + HDR_B;
        bump_end = bump_end + sz + OVH_B;
        return ST_OK;
    endfunction

    function automatic logic [STAT_W-1:0] release_block(int unsigned addr);
        int unsigned off;
        int unsigned hd;
        int unsigned sz;
        int unsigned nh;
        int unsigned psz;
        int unsigned ph;
        if (addr < cfg_base + HDR_B || addr >= cfg_base + bump_end)
            return ST_INVALID;
        off = addr - cfg_base;
        if ((off & 7) != 0)
            return ST_INVALID;
        hd = off - HDR_B;
        if (mem_rd(hd) == 0)
            return ST_INVALID;
        sz = mem_rd(hd + 8);
        nh = off + sz + 8;
        if (nh < bump_end && mem_rd(nh) == 0)
        begin
            unlink_node(nh);
            sz += mem_rd(nh + 8) + OVH_B;
        end
        if (hd > 0)
        begin
            psz = mem_rd(off - 24);
            ph = off - SPLIT_B - psz;
            if (mem_rd(ph) == 0)
            begin
                unlink_node(ph);
                sz += psz + OVH_B;
                hd = ph;
            end
        end
        mem_wr(hd, 0);
        mem_wr(hd + 8, sz);
        mem_wr(hd + HDR_B + sz, sz);
        push_node(hd);
        return ST_OK;
    endfunction

    function automatic grant_t serve_request(logic [TYPE_W-1:0] kind, int unsigned size,
                                             int unsigned addr);
        grant_t      g;
        int unsigned off;
        g.status = ST_INVALID;
        g.block_addr = '0;
        if (kind == RQ_ALLOC)
        begin
            g.status = carve_block(size, off);
            if (g.status == ST_OK)
                g.block_addr = ADDR_W'(cfg_base + off);
        end
        else if (kind == RQ_FREE)
            g.status = release_block(addr);
        else if (kind == RQ_RESET)
        begin
            bump_end = 0;
            list_head = 0;
            list_busy = 1'b0;
            g.status = ST_OK;
        end
        return g;
    endfunction

    task automatic drive_request(logic [TYPE_W-1:0] kind, int unsigned size, int unsigned addr);
        req_ch.valid    <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.req_size <= SIZE_W'(size);
        req_ch.req_addr <= ADDR_W'(addr);
        do
            @(posedge clk);
        while (!req_ch.ready);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // Predict first; a request that would read never-written heap words becomes a low bad free.
    task automatic issue(logic [TYPE_W-1:0] kind, int unsigned size, int unsigned addr,
                         bit typed = 1'b0, logic [STAT_W-1:0] st = ST_OK,
                         logic [ADDR_W-1:0] ba = '0);
        grant_t      g;
        int unsigned bump_keep;
        int unsigned head_keep;
        bit          busy_keep;
        mem_keep = heap_mem;
        set_keep = heap_set;
        bump_keep = bump_end;
        head_keep = list_head;
        busy_keep = list_busy;
        read_unset = 1'b0;
        g = serve_request(kind, size, addr);
        if (read_unset)
        begin
            heap_mem = mem_keep;
            heap_set = set_keep;
            bump_end = bump_keep;
            list_head = head_keep;
            list_busy = busy_keep;
            kind = RQ_FREE;
            addr = $urandom_range(0, cfg_base + 15);
            g = serve_request(kind, size, addr);
        end
        if (kind == RQ_ALLOC && g.status == ST_OK)
            live_blocks.push_back(g.block_addr);
        if (kind == RQ_FREE && g.status == ST_OK)
        begin
            foreach (live_blocks[i])
                if (live_blocks[i] == addr)
                begin
                    live_blocks.delete(i);
                    break;
                end
            freed_blocks.push_back(addr);
            if (freed_blocks.size() > 32)
                void'(freed_blocks.pop_front());
        end
        if (kind == RQ_RESET)
            live_blocks.delete();
        case (g.status)
            ST_OK:      if (kind == RQ_ALLOC) n_grant++; else n_release++;
            ST_NOSPACE: n_nospace++;
            default:    n_invalid++;
        endcase
        if (typed)
        begin
            g.status = st;
            g.block_addr = ba;
        end
        pending_grants.push_back(g);
        drive_request(kind, size, addr);
    endtask

    task automatic drain_and_settle();
        req_ch.valid <= 1'b0;
        while (pending_grants.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic sel, int unsigned value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == REG_BASE)
            cfg_base = value & 16'hFFFF;
        else
            cfg_limit = value & 16'hFFFF;
        @(posedge clk);
    endtask

    task automatic random_request();
        int unsigned r;
        int unsigned sz;
        r = $urandom_range(0, 99);
        if (r < 50 || (r < 85 && live_blocks.size() == 0))
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                sz = $urandom_range(0, 64);
            else if (r < 95)
                sz = $urandom_range(65, 600);
            else if (r < 99)
                sz = $urandom_range(601, 4000);
            else
                sz = $urandom_range(32700, 32768);
            issue(RQ_ALLOC, sz, $urandom_range(0, 131071));
        end
        else if (r < 85)
            issue(RQ_FREE, $urandom_range(0, 65535),
                  live_blocks[$urandom_range(0, live_blocks.size() - 1)]);
        else if (r < 93)
            issue(RQ_FREE, $urandom_range(0, 65535), $urandom_range(0, 131071));
        else if (r < 96 && freed_blocks.size() != 0)
            issue(RQ_FREE, 0, freed_blocks[$urandom_range(0, freed_blocks.size() - 1)]);
        else if (r < 98)
            issue(RQ_BAD, $urandom_range(0, 65535), $urandom_range(0, 131071));
        else
            issue(RQ_RESET, $urandom_range(0, 65535), $urandom_range(0, 131071));
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("FAIL free_list_heap_allocator");
            $finish;
        end
    end

    initial
    begin
        int hold;
        bit long_done;
        grant_t g;
        hold = 0;
        long_done = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (pending_grants.size() == 0)
                begin
                    $error("response with nothing pending: status %0d block_addr %0d",
                           rsp_ch.status, rsp_ch.block_addr);
                    fails++;
                end
                else
                begin
                    g = pending_grants.pop_front();
                    if (rsp_ch.status !== g.status)
                    begin
                        $error("status expected %0d actual %0d", g.status, rsp_ch.status);
                        fails++;
                    end
                    if (rsp_ch.block_addr !== g.block_addr)
                    begin
                        $error("block_addr expected %0d actual %0d",
                               g.block_addr, rsp_ch.block_addr);
                        fails++;
                    end
                end
                checked++;
            end
            if (hold > 0)
            begin
                hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!long_done && checked >= 500)
            begin
                long_done = 1'b1;
                hold = 400;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                hold = $urandom_range(1, 19);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        int unsigned plan_base [6];
        int unsigned plan_limit[6];
        int          plan_count[6];
        int          waited;
        plan_base  = '{0, 4096, 65535, 0, 777, 12345};
        plan_limit = '{32768, 2000, 65535, 0, 32768, 40000};
        plan_count = '{500, 300, 350, 30, 300, 170};
        rows = '{
            '{RQ_ALLOC, 0,     0,   1'b1, ST_OK,      17'd16},
            '{RQ_ALLOC, 1,     0,   1'b1, ST_OK,      17'd56},
            '{RQ_ALLOC, 32768, 0,   1'b1, ST_NOSPACE, 17'd0},
            '{RQ_FREE,  0,     0,   1'b1, ST_INVALID, 17'd0},
            '{RQ_FREE,  0,     57,  1'b1, ST_INVALID, 17'd0},
            '{RQ_FREE,  0,     80,  1'b1, ST_INVALID, 17'd0},
            '{RQ_BAD,   65535, 0,   1'b1, ST_INVALID, 17'd0},
            '{RQ_FREE,  0,     16,  1'b1, ST_OK,      17'd0},
            '{RQ_FREE,  0,     16,  1'b1, ST_INVALID, 17'd0},
            '{RQ_FREE,  0,     56,  1'b1, ST_OK,      17'd0},
            '{RQ_ALLOC, 200,   0,   1'b1, ST_OK,      17'd96},
            '{RQ_ALLOC, 9,     0,   1'b0, ST_OK,      17'd0},
            '{RQ_ALLOC, 16,    0,   1'b0, ST_OK,      17'd0},
            '{RQ_ALLOC, 0,     0,   1'b0, ST_OK,      17'd0},
            '{RQ_RESET, 0,     0,   1'b1, ST_OK,      17'd0},
            '{RQ_ALLOC, 32744, 0,   1'b1, ST_OK,      17'd16},
            '{RQ_ALLOC, 0,     0,   1'b1, ST_NOSPACE, 17'd0},
            '{RQ_FREE,  0,     16,  1'b1, ST_OK,      17'd0},
            '{RQ_ALLOC, 32768, 0,   1'b1, ST_NOSPACE, 17'd0},
            '{RQ_ALLOC, 100,   0,   1'b0, ST_OK,      17'd0},
            '{RQ_RESET, 0,     0,   1'b1, ST_OK,      17'd0}
        };
        fails = 0;
        checked = 0;
        cycles = 0;
        calm = 1'b0;
        bump_end = 0;
        list_head = 0;
        list_busy = 1'b0;
        cfg_base = 0;
        cfg_limit = LIMIT_RST;
        foreach (heap_mem[i])
        begin
            heap_mem[i] = 0;
            heap_set[i] = 1'b0;
        end
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        req_ch.valid = 1'b0;
        req_ch.req_type = RQ_ALLOC;
        req_ch.req_size = '0;
        req_ch.req_addr = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
            issue(rows[i].kind, rows[i].size, rows[i].addr, rows[i].typed,
                  rows[i].status, rows[i].block_addr);

        for (int p = 0; p < 6; p++)
        begin
            drain_and_settle();
            write_reg(REG_BASE, plan_base[p]);
            write_reg(REG_LIMIT, plan_limit[p]);
            issue(RQ_RESET, 0, 0);
            for (int k = 0; k < plan_count[p]; k++)
            begin
                if (p == 5 && k >= 20)
                    calm = 1'b1;
                if (p == 0 && k == 250)
                    drain_and_settle();
                random_request();
            end
        end

        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_grants.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (60) @(posedge clk);
        $display("covered %0d grants, %0d no-space, %0d releases/resets, %0d rejected",
                 n_grant, n_nospace, n_release, n_invalid);
        $display("over 7 base/limit settings with %0d responses checked", checked);
        if (fails == 0 && pending_grants.size() == 0)
            $display("PASS free_list_heap_allocator");
        else
            $display("FAIL free_list_heap_allocator");
        $finish;
    end

endmodule

[sim.f]
design/fla_pkg.sv
design/fla_if.sv
design/fla_mem.sv
design/fla_ctrl.sv
design/free_list_heap_allocator.sv
sim/tb.sv
